// ===== hdl/crfa_pkg.sv =====
// Shared types, constants and layout of the range frame averager.
package crfa_pkg;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam int ID_W     = 11;
  localparam int BYTE_W   = 8;
  localparam int TIME_W   = 32;
  localparam int TMO_W    = 16;
  localparam int QUO_W    = 8;
  localparam int QBIT_W   = $clog2(QUO_W);

  localparam int COUNT_MAX_DEF = 1023;

  localparam logic [ID_W-1:0]  ACCEPT_ID_RST = '0;
  localparam logic [TMO_W-1:0] TIMEOUT_RST   = 16'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEPT_ID = 1'b0,
    CFG_TIMEOUT   = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    CMD_FRAME = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PROC = 2'd1,
    ST_DIV  = 2'd2,
    ST_LOAD = 2'd3
  } ctrl_state_t;

  typedef struct packed {
    logic latch_in;
    logic proc;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic has_samples;
    logic div_last;
  } ctrl_sts_t;

endpackage

// ===== hdl/crfa_ctrl.sv =====
// Sequencer that steps one item through filter, divide and output load.
module crfa_ctrl
  import crfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_PROC;
        end
      end
      ST_PROC: begin
        cmd.proc = 1'b1;
        if (sts.is_tick && sts.has_samples) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_LOAD;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/crfa_dp.sv =====
// Datapath with id filter, checksum, accumulator, mean divider and result register.
module crfa_dp
  import crfa_pkg::*;
#(
  parameter int COUNT_MAX = COUNT_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_user,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  ctrl_cmd_t              cmd,
  output ctrl_sts_t              sts,
  output logic [OUT_TDATA_W-1:0] out_data
);

  localparam int CNT_W = $clog2(COUNT_MAX + 1);
  localparam int SUM_W = $clog2(COUNT_MAX * 255 + 1);
  localparam int CMP_W = CNT_W + QUO_W;

  logic                   cmd_r;
  logic [ID_W-1:0]        id_r;
  logic [BYTE_W-1:0]      b3_r, b4_r, dist_r, b6_r, chk_r;
  logic [TIME_W-1:0]      now_r;

  logic [ID_W-1:0]        accept_id_r;
  logic [TMO_W-1:0]       timeout_r;
  logic                   locked_r;
  logic [ID_W-1:0]        locked_id_r;
  logic [SUM_W-1:0]       sum_r;
  logic [CNT_W-1:0]       count_r;
  logic [TIME_W-1:0]      stamp_r;
  logic [QUO_W-1:0]       avg_r;

  logic                   acc_res_r, fresh_res_r, nodata_res_r;
  logic [SUM_W-1:0]       rem_r;
  logic [QUO_W-1:0]       quo_r, quo_nxt;
  logic [QBIT_W-1:0]      bit_r;
  logic [OUT_TDATA_W-1:0] out_r;

  logic                   pass, chk_ok, is_tick, has_samples, timed_out, ge;
  logic [BYTE_W-1:0]      csum;
  logic [TIME_W-1:0]      elapsed;
  logic [CMP_W-1:0]       rem_ext, divisor_sh;

  assign is_tick     = (cmd_r == CMD_TICK);
  assign has_samples = (count_r != '0);
  assign pass        = ((accept_id_r == '0) || (id_r == accept_id_r)) &&
                       (!locked_r || (id_r == locked_id_r));
  assign csum        = b3_r + b4_r + dist_r + b6_r;
  assign chk_ok      = (csum == chk_r);
  assign elapsed     = now_r - stamp_r;
  assign timed_out   = (elapsed > TIME_W'(timeout_r));
  assign rem_ext     = CMP_W'(rem_r);
  assign divisor_sh  = CMP_W'(count_r) << bit_r;
  assign ge          = (rem_ext >= divisor_sh);

  always_comb begin
    quo_nxt        = quo_r;
    quo_nxt[bit_r] = ge;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r  <= in_user;
      id_r   <= in_data[10:0];
      b3_r   <= in_data[18:11];
      b4_r   <= in_data[26:19];
      dist_r <= in_data[34:27];
      b6_r   <= in_data[42:35];
      chk_r  <= in_data[50:43];
      now_r  <= in_data[82:51];
    end
    if (cmd.proc) begin
      rem_r <= sum_r;
      quo_r <= '0;
      bit_r <= QBIT_W'(QUO_W - 1);
      acc_res_r    <= !is_tick && pass && chk_ok;
      fresh_res_r  <= is_tick && has_samples;
      nodata_res_r <= is_tick && !has_samples && timed_out;
    end
    if (cmd.div_step) begin
      quo_r <= quo_nxt;
      bit_r <= bit_r - 1'b1;
      if (ge) begin
        rem_r <= SUM_W'(rem_ext - divisor_sh);
      end
    end
    if (cmd.load_out) begin
      out_r <= {5'b0, nodata_res_r, fresh_res_r, avg_r, acc_res_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accept_id_r <= ACCEPT_ID_RST;
      timeout_r   <= TIMEOUT_RST;
      locked_r    <= 1'b0;
      locked_id_r <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      stamp_r     <= '0;
      avg_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ACCEPT_ID: accept_id_r <= cfg_data[ID_W-1:0];
          CFG_TIMEOUT:   timeout_r   <= cfg_data[TMO_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.proc) begin
        if (!is_tick) begin
          if (pass) begin
            locked_r    <= 1'b1;
            locked_id_r <= id_r;
            if (chk_ok && (count_r < CNT_W'(COUNT_MAX))) begin
              sum_r   <= sum_r + SUM_W'(dist_r);
              count_r <= count_r + 1'b1;
            end
          end
        end else if (has_samples) begin
          stamp_r <= now_r;
          sum_r   <= '0;
        end
      end
      if (cmd.div_step && (bit_r == '0)) begin
        avg_r   <= quo_nxt;
        count_r <= '0;
      end
    end
  end

  assign sts.is_tick     = is_tick;
  assign sts.has_samples = has_samples;
  assign sts.div_last    = (bit_r == '0);
  assign out_data        = out_r;

endmodule

// ===== hdl/can_range_frame_averager_top.sv =====
// Top level of the CAN range frame averager.
//
//  Channel  Handshake              Payload
//  in       in_tvalid/in_tready    in_tuser = cmd, in_tdata = frame and time fields
//  out      out_tvalid/out_tready  out_tdata = accepted, distance, fresh, no data
//  cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A frame or an empty tick runs from the transfer through the PROC state to the LOAD
// state, where its result is loaded. A tick with samples runs the DIV state between
// the two, where the mean divider takes one quotient bit a cycle. One item is in work
// at a time; a finished result waits in the output register while the next item is
// taken, and that item then waits for the load until the register is free. Reset is
// synchronous and needs no clearing pass. Configuration writes are always taken.
module can_range_frame_averager_top
  import crfa_pkg::*;
#(
  parameter int COUNT_MAX = COUNT_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic                   in_tuser,   // [0] cmd
  // [10:0] frame_id, [18:11] byte3, [26:19] byte4, [34:27] distance_byte,
  // [42:35] byte6, [50:43] check_byte, [82:51] now_ms, [87:83] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] frame_accepted, [8:1] averaged distance in cm, [9] fresh_reading,
  // [10] no_data, [15:11] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  crfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  crfa_dp #(
    .COUNT_MAX (COUNT_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_user   (in_tuser),
    .in_data   (in_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_tdata)
  );

endmodule

// ===== hdl/crfa_checker.sv =====
// Port-level checks of the averager, bound to the top level.
module crfa_checker
  import crfa_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Only one item is in work at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  // A result never carries more than one of its event flags.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[9] && out_tdata[10]) &&
                   !(out_tdata[0] && (out_tdata[9] || out_tdata[10])))
    else $error("conflicting result flags");

  // A frame taken while the output is empty reaches the output with no tick flags.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !out_tvalid |->
      ##3 (out_tvalid && !out_tdata[9] && !out_tdata[10]))
    else $error("frame result late or flagged as a tick");

endmodule

bind can_range_frame_averager_top crfa_checker u_crfa_checker (.*);
